>>> rtl/ossu_pkg.sv
// Package for the operand stack shuffle unit: operation codes, transaction
// structs, field widths, cost constants and parameter defaults.
// No dependencies.
`default_nettype none

package ossu_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_WIDTH_DEF  = 32;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int DEPTH_W = 5;
    localparam int COST_W  = 5;

    localparam int ROT_DEPTH = 2;

    localparam logic [COST_W-1:0] COST_ONE  = COST_W'(1);
    localparam logic [COST_W-1:0] COST_SWAP = COST_W'(2);
    localparam logic [COST_W-1:0] COST_ROT  = COST_W'(3);
    localparam logic [COST_W-1:0] COST_NONE = COST_W'(0);

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_EAT     = 3'd1,
        OP_DUP     = 3'd2,
        OP_SWAP    = 3'd3,
        OP_YANK    = 3'd4,
        OP_YANKDUP = 3'd5,
        OP_ROTATE  = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] push_value;
        logic [INDEX_W-1:0]        depth_index;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic [DEPTH_W-1:0]        stack_depth;
        logic [COST_W-1:0]         op_cost;
        logic                      fault;
    } t_out;

endpackage

`default_nettype wire

>>> rtl/operand_stack_shuffle_unit_top.sv
// Operand stack shuffle unit, top level: handshake and result register.
// Depends on ossu_pkg and ossu_core.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries one operation
//   per transaction (push, eat, dup, swap, yank, yankdup, rotate, clear).
//   Output channel o_out_valid / i_out_stall / o_out_data returns exactly
//   one result per transaction: new top, depth, cost and fault flag.
//   o_out_valid rises in the cycle after acceptance; throughput is one
//   transaction per cycle while the receiver does not stall, set by the
//   combinational stack update in ossu_core feeding one result register.
//   The stack updates at the accepting edge, so back-to-back transactions
//   see each other's effect. A faulting transaction leaves the stack as is.
//   When the receiver stalls with a result held, o_in_stall rises and the
//   result stays put; the register frees the same cycle the stall drops.
//   Reset (synchronous, active low) empties the stack and drops o_out_valid;
//   stack words are not cleared and are never read before being written.
`default_nettype none

module operand_stack_shuffle_unit_top
    import ossu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic in_accept;
    t_out step_result;
    logic r_out_valid;
    t_out r_out_data;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    ossu_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_in     (i_in_data),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !in_accept)
        else $error("input accepted while a held result is stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");
`endif

endmodule

`default_nettype wire

>>> rtl/ossu_core.sv
// Stack storage and combinational operation datapath, top-first order.
// Depends on ossu_pkg.
`default_nettype none

module ossu_core
    import ossu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_in  i_in,
    output t_out      o_result
);

    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int IW    = $clog2(STACK_DEPTH);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    logic [WORD_WIDTH-1:0] r_words [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] n_words [STACK_DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;

    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      idx_ext;
    logic                  is_full;
    logic                  is_empty;
    logic                  bad_idx;
    logic                  fault;
    logic [COST_W-1:0]     cost;
    logic [IW-1:0]         sel_idx;
    logic [WORD_WIDTH-1:0] sel_word;
    logic [WORD_WIDTH-1:0] new_word;
    logic                  do_grow;
    logic                  do_lift;
    logic                  do_pop;
    logic                  do_swap;

    assign cnt_ext  = CMP_W'(r_count);
    assign idx_ext  = CMP_W'(i_in.depth_index);
    assign is_full  = (r_count >= CW'(STACK_DEPTH));
    assign is_empty = (r_count == '0);
    assign bad_idx  = (idx_ext >= cnt_ext);

    assign sel_idx  = (i_in.op == OP_ROTATE) ? IW'(ROT_DEPTH) : IW'(i_in.depth_index);
    assign sel_word = r_words[sel_idx];

    always_comb begin
        fault    = 1'b0;
        cost     = COST_ONE;
        do_grow  = 1'b0;
        do_lift  = 1'b0;
        do_pop   = 1'b0;
        do_swap  = 1'b0;
        new_word = sel_word;
        n_count  = r_count;
        unique case (i_in.op)
            OP_PUSH: begin
                fault    = is_full;
                do_grow  = 1'b1;
                new_word = WORD_WIDTH'(i_in.push_value);
            end
            OP_EAT: begin
                fault  = is_empty;
                do_pop = 1'b1;
            end
            OP_DUP: begin
                fault    = is_empty || is_full;
                do_grow  = 1'b1;
                new_word = r_words[0];
            end
            OP_SWAP: begin
                fault   = (r_count < CW'(2));
                do_swap = 1'b1;
                cost    = COST_SWAP;
            end
            OP_YANK: begin
                fault   = bad_idx;
                do_lift = 1'b1;
                cost    = COST_W'(i_in.depth_index) + COST_ONE;
            end
            OP_YANKDUP: begin
                fault   = bad_idx || is_full;
                do_grow = 1'b1;
                cost    = COST_W'(i_in.depth_index) + COST_ONE;
            end
            OP_ROTATE: begin
                fault   = (r_count < CW'(3));
                do_lift = 1'b1;
                cost    = COST_ROT;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
        endcase

        if (fault) begin
            cost    = COST_NONE;
            do_grow = 1'b0;
            do_lift = 1'b0;
            do_pop  = 1'b0;
            do_swap = 1'b0;
        end
        if (do_grow) begin
            n_count = r_count + CW'(1);
        end
        if (do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // per-entry next value; entry 0 is the top
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            n_words[i] = r_words[i];
        end
        if (do_grow || do_lift) begin
            n_words[0] = new_word;
        end
        if (do_swap) begin
            n_words[0] = r_words[1];
            n_words[1] = r_words[0];
        end
        for (int i = 1; i < STACK_DEPTH; i++) begin
            if (do_grow || (do_lift && (i <= int'(sel_idx)))) begin
                n_words[i] = r_words[i-1];
            end
        end
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            if (do_pop) begin
                n_words[i] = r_words[i+1];
            end
        end
    end

    always_comb begin
        o_result.top_value   = (n_count == '0) ? '0 : VALUE_W'(signed'(n_words[0]));
        o_result.stack_depth = DEPTH_W'(n_count);
        o_result.op_cost     = cost;
        o_result.fault       = fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_words[i] <= n_words[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("element count above stack depth");

    a_fault_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && fault) |=> (r_count == $past(r_count)))
        else $error("faulting transaction changed the element count");

    a_fault_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !fault) |-> (cost != COST_NONE || i_in.depth_index[COST_W-1:0] == '1))
        else $error("successful transaction reported zero cost");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in.op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left elements on the stack");
`endif

endmodule

`default_nettype wire
